// ===== rtl/eight_bit_cpu_move_alu_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the eight-bit CPU core
// Implication checks sampled on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_MOVE_ALU_CORE_ASSERT_SVH
`define EIGHT_BIT_CPU_MOVE_ALU_CORE_ASSERT_SVH

// Same-cycle implication
`define EBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define EBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ebc_pkg.sv =====
// ---------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants of the eight-bit CPU core.
// ---------------------------------------------------------------------------
package ebc_pkg;

  // Byte memory size
  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;

  // Commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DONE,
    ST_RDATA,
    ST_OPC,
    ST_LXI1,
    ST_LXI2,
    ST_MEMOP
  } state_t;

  // ALU operations, coded as opcode bits 5:3 of the 0x80-0xA7 group
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBB = 3'd3,
    ALU_ANA = 3'd4
  } alu_op_t;

  // Opcodes with special handling
  localparam logic [7:0] OP_LXI_B = 8'h01;
  localparam logic [7:0] OP_CMA   = 8'h2F;
  localparam logic [7:0] OP_HLT   = 8'h76;

  // Register selector codes
  localparam logic [2:0] SEL_B = 3'd0;
  localparam logic [2:0] SEL_C = 3'd1;
  localparam logic [2:0] SEL_D = 3'd2;
  localparam logic [2:0] SEL_E = 3'd3;
  localparam logic [2:0] SEL_H = 3'd4;
  localparam logic [2:0] SEL_L = 3'd5;
  localparam logic [2:0] SEL_M = 3'd6;
  localparam logic [2:0] SEL_A = 3'd7;

  // Flag bit positions
  localparam int FLAG_CY = 0;
  localparam int FLAG_P  = 1;
  localparam int FLAG_AC = 2;
  localparam int FLAG_Z  = 3;
  localparam int FLAG_S  = 4;

  // ALU result bundle
  typedef struct packed {
    logic [7:0] res;
    logic [4:0] flags;
  } alu_res_t;

endpackage

// ===== rtl/eight_bit_cpu_move_alu_core.sv =====
// ---------------------------------------------------------------------------
// eight_bit_cpu_move_alu_core
// Small 8-bit CPU (NOP, LXI B, CMA, MOV, ADD/ADC/SUB/SBB/ANA) with a byte RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream: write a RAM byte, execute the
//   instruction at PC, or read a RAM byte. Every command gives exactly one
//   result transfer on the m_ stream carrying PC, A, B..L, flags and the
//   read byte (zero unless the command was a read), all after the command.
//   Each command steps through these states before its result is
//   registered, as the single RAM port has registered read data:
//     write, unused code: ST_DONE; read: ST_RDATA
//     execute, register operands, MOV M,r or CMA/NOP/HLT: ST_OPC
//     execute, M operand: ST_OPC, ST_MEMOP
//     execute, LXI B (two operand fetches): ST_OPC, ST_LXI1, ST_LXI2
//   The next command is taken in the cycle its predecessor finishes, so
//   reads, writes and register instructions run at one per cycle while
//   the receiver keeps up; MOV M,r occupies the port for its write, so the
//   next command waits until the core is back in ST_IDLE.
//   Reset clears PC, A, B..L and flags; the RAM is not cleared and must be
//   written before it is read. A stalled receiver holds the result in the
//   output register; one more command may be in flight behind it.
// ---------------------------------------------------------------------------
module eight_bit_cpu_move_alu_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // command[1:0], address[17:2], data[25:18], zero fill
  input  logic [ebc_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // prog_counter[15:0], acc[23:16], reg_b[31:24], reg_c[39:32],
  // reg_d[47:40], reg_e[55:48], reg_h[63:56], reg_l[71:64],
  // flag_bits[76:72], read_data[84:77], zero fill
  output logic [ebc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int AW = ebc_pkg::MEM_ADDR_BITS;

  // Architectural registers
  ebc_pkg::state_t state, state_next;
  logic [15:0] pc, pc_next;
  logic [7:0]  a, a_next;
  logic [7:0]  b, b_next, c, c_next, d, d_next, e, e_next, h, h_next, l, l_next;
  logic [4:0]  flags, flags_next;
  logic [7:0]  opc;

  // RAM port
  logic [7:0]    mem [ebc_pkg::MEM_DEPTH];
  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rdata;

  // Input fields
  ebc_pkg::cmd_t in_cmd;
  logic [15:0]   in_addr;
  logic [7:0]    in_data;
  logic          accept;

  // Decode and control
  logic [7:0]  op_cur;
  logic        is_lxi, is_cma, is_mov, is_alu, src_m, dst_m, need_rd, mov_wr;
  logic        fin, fin_go, port_busy, out_free, do_exec;
  logic [7:0]  src_val, rd_byte;
  logic [15:0] pc_plus1, pc_plus2, pc_plus3, hl;
  ebc_pkg::alu_res_t alu_out;

  function automatic logic [7:0] get_reg(input logic [2:0] sel, input logic [7:0] ra,
                                         input logic [7:0] rb, input logic [7:0] rc,
                                         input logic [7:0] rd, input logic [7:0] re,
                                         input logic [7:0] rh, input logic [7:0] rl);
    logic [7:0] v;
    case (sel)
      ebc_pkg::SEL_B: v = rb;
      ebc_pkg::SEL_C: v = rc;
      ebc_pkg::SEL_D: v = rd;
      ebc_pkg::SEL_E: v = re;
      ebc_pkg::SEL_H: v = rh;
      ebc_pkg::SEL_L: v = rl;
      ebc_pkg::SEL_A: v = ra;
      default:        v = 8'd0;
    endcase
    return v;
  endfunction

  // Unpack command
  assign in_cmd  = ebc_pkg::cmd_t'(s_tdata[1:0]);
  assign in_addr = s_tdata[17:2];
  assign in_data = s_tdata[25:18];

  // Opcode arrives from the RAM in ST_OPC, later from the latch
  assign op_cur  = (state == ebc_pkg::ST_OPC) ? rdata : opc;
  assign is_lxi  = (op_cur == ebc_pkg::OP_LXI_B);
  assign is_cma  = (op_cur == ebc_pkg::OP_CMA);
  assign is_mov  = (op_cur[7:6] == 2'b01) && (op_cur != ebc_pkg::OP_HLT);
  assign is_alu  = (op_cur[7:6] == 2'b10) && !(op_cur[5] && (op_cur[4] || op_cur[3]));
  assign src_m   = (op_cur[2:0] == ebc_pkg::SEL_M);
  assign dst_m   = (op_cur[5:3] == ebc_pkg::SEL_M);
  assign need_rd = (is_mov || is_alu) && src_m;
  assign mov_wr  = is_mov && dst_m && !src_m;

  assign pc_plus1 = pc + 16'd1;
  assign pc_plus2 = pc + 16'd2;
  assign pc_plus3 = pc + 16'd3;
  assign hl       = {h, l};

  // Finishing states and handshake
  assign fin = (state == ebc_pkg::ST_DONE) || (state == ebc_pkg::ST_RDATA) ||
               (state == ebc_pkg::ST_LXI2) || (state == ebc_pkg::ST_MEMOP) ||
               ((state == ebc_pkg::ST_OPC) && !is_lxi && !need_rd);
  assign out_free  = !m_tvalid || m_tready;
  assign fin_go    = fin && out_free;
  assign port_busy = (state == ebc_pkg::ST_OPC) && mov_wr;
  assign s_tready  = (state == ebc_pkg::ST_IDLE) || (fin_go && !port_busy);
  assign accept    = s_tvalid && s_tready;
  assign do_exec   = fin_go && ((state == ebc_pkg::ST_OPC) || (state == ebc_pkg::ST_MEMOP));

  // Source operand: RAM byte for M forms, else a register
  assign src_val = (state == ebc_pkg::ST_MEMOP) ? rdata :
                   get_reg(op_cur[2:0], a, b, c, d, e, h, l);

  ebc_alu u_alu (
    .a      (a),
    .x      (src_val),
    .cin    (flags[ebc_pkg::FLAG_CY]),
    .op     (ebc_pkg::alu_op_t'(op_cur[5:3])),
    .result (alu_out)
  );

  // Sequence the RAM port and compute next register values
  always_comb begin
    state_next = state;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = pc[AW-1:0];
    mem_wdata  = in_data;
    pc_next    = pc;
    a_next     = a;
    b_next     = b;
    c_next     = c;
    d_next     = d;
    e_next     = e;
    h_next     = h;
    l_next     = l;
    flags_next = flags;
    rd_byte    = 8'd0;

    case (state)
      ebc_pkg::ST_IDLE: begin
      end
      ebc_pkg::ST_DONE: begin
      end
      ebc_pkg::ST_RDATA: begin
        rd_byte = rdata;
      end
      ebc_pkg::ST_OPC: begin
        if (is_lxi) begin
          mem_en     = 1'b1;
          mem_addr   = pc_plus1[AW-1:0];
          state_next = ebc_pkg::ST_LXI1;
        end else if (need_rd) begin
          mem_en     = 1'b1;
          mem_addr   = hl[AW-1:0];
          state_next = ebc_pkg::ST_MEMOP;
        end else if (mov_wr) begin
          mem_en    = fin_go;
          mem_we    = 1'b1;
          mem_addr  = hl[AW-1:0];
          mem_wdata = src_val;
        end
      end
      ebc_pkg::ST_LXI1: begin
        c_next     = rdata;
        mem_en     = 1'b1;
        mem_addr   = pc_plus2[AW-1:0];
        state_next = ebc_pkg::ST_LXI2;
      end
      ebc_pkg::ST_LXI2: begin
        if (fin_go) begin
          b_next  = rdata;
          pc_next = pc_plus3;
        end
      end
      ebc_pkg::ST_MEMOP: begin
      end
      default: begin
        state_next = ebc_pkg::ST_IDLE;
      end
    endcase

    // Apply the instruction
    if (do_exec) begin
      pc_next = pc_plus1;
      if (is_cma) begin
        a_next = ~a;
      end
      if (is_mov) begin
        case (op_cur[5:3])
          ebc_pkg::SEL_B: b_next = src_val;
          ebc_pkg::SEL_C: c_next = src_val;
          ebc_pkg::SEL_D: d_next = src_val;
          ebc_pkg::SEL_E: e_next = src_val;
          ebc_pkg::SEL_H: h_next = src_val;
          ebc_pkg::SEL_L: l_next = src_val;
          ebc_pkg::SEL_A: a_next = src_val;
          default: begin
          end
        endcase
      end
      if (is_alu) begin
        a_next     = alu_out.res;
        flags_next = alu_out.flags;
      end
    end

    if (fin_go) begin
      state_next = ebc_pkg::ST_IDLE;
    end

    // Start the next command; the port is free whenever accept is high
    if (accept) begin
      case (in_cmd)
        ebc_pkg::CMD_WRITE: begin
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = in_addr[AW-1:0];
          mem_wdata  = in_data;
          state_next = ebc_pkg::ST_DONE;
        end
        ebc_pkg::CMD_EXEC: begin
          mem_en     = 1'b1;
          mem_we     = 1'b0;
          mem_addr   = pc_next[AW-1:0];
          state_next = ebc_pkg::ST_OPC;
        end
        ebc_pkg::CMD_READ: begin
          mem_en     = 1'b1;
          mem_we     = 1'b0;
          mem_addr   = in_addr[AW-1:0];
          state_next = ebc_pkg::ST_RDATA;
        end
        default: begin
          state_next = ebc_pkg::ST_DONE;
        end
      endcase
    end
  end

  // RAM: one access per cycle, read data held until the next read
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        rdata <= mem[mem_addr];
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= 16'd0;
      a     <= 8'd0;
      b     <= 8'd0;
      c     <= 8'd0;
      d     <= 8'd0;
      e     <= 8'd0;
      h     <= 8'd0;
      l     <= 8'd0;
      flags <= 5'd0;
    end else begin
      pc    <= pc_next;
      a     <= a_next;
      b     <= b_next;
      c     <= c_next;
      d     <= d_next;
      e     <= e_next;
      h     <= h_next;
      l     <= l_next;
      flags <= flags_next;
    end
  end

  // Latch the opcode for multi-cycle instructions
  always_ff @(posedge clk) begin
    if (state == ebc_pkg::ST_OPC) begin
      opc <= rdata;
    end
  end

  // Output register: load on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      m_tdata <= {3'd0, rd_byte, flags_next, l_next, h_next, e_next, d_next,
                  c_next, b_next, a_next, pc_next};
    end
  end

  // Checks
  `include "eight_bit_cpu_move_alu_core_assert.svh"

  `EBC_ASSERT_NOW(a_accept_at_finish, accept && (state != ebc_pkg::ST_IDLE), fin_go && !port_busy, "command taken while the previous one was still running")
  `EBC_ASSERT_NEXT(a_lxi_two_fetches, state == ebc_pkg::ST_LXI1, state == ebc_pkg::ST_LXI2, "LXI second operand fetch skipped")
  `EBC_ASSERT_NOW(a_memop_read, (state == ebc_pkg::ST_MEMOP) && ($past(state) != ebc_pkg::ST_MEMOP), $past(mem_en && !mem_we), "M operand used without a RAM read")
  `EBC_ASSERT_NEXT(a_lxi_pc_step, fin_go && (state == ebc_pkg::ST_LXI2), pc == ($past(pc) + 16'd3), "LXI did not advance PC by three")
  `EBC_ASSERT_NEXT(a_result_loaded, fin_go, m_tvalid, "finished command produced no result")

endmodule

// ===== rtl/ebc_alu.sv =====
// ---------------------------------------------------------------------------
// ebc_alu
// Accumulator ALU: ADD, ADC, SUB, SBB, ANA with S, Z, AC, P, CY flags.
// ---------------------------------------------------------------------------
module ebc_alu (
  input  logic              [7:0] a,
  input  logic              [7:0] x,
  input  logic                    cin,
  input  ebc_pkg::alu_op_t        op,
  output ebc_pkg::alu_res_t       result
);

  logic       c;
  logic [8:0] sum9;
  logic [4:0] nib;
  logic [8:0] sub9;
  logic [8:0] diff9;
  logic [7:0] res;
  logic       cy;
  logic       ac;

  // Carry-in only for the with-carry forms
  assign c     = ((op == ebc_pkg::ALU_ADC) || (op == ebc_pkg::ALU_SBB)) ? cin : 1'b0;
  assign sum9  = {1'b0, a} + {1'b0, x} + {8'd0, c};
  assign nib   = {1'b0, a[3:0]} + {1'b0, x[3:0]} + {4'd0, c};
  assign sub9  = {1'b0, x} + {8'd0, c};
  assign diff9 = {1'b0, a} - sub9;

  // Select result, carry and aux carry
  always_comb begin
    case (op)
      ebc_pkg::ALU_ADD, ebc_pkg::ALU_ADC: begin
        res = sum9[7:0];
        cy  = sum9[8];
        ac  = nib[4];
      end
      ebc_pkg::ALU_SUB, ebc_pkg::ALU_SBB: begin
        res = diff9[7:0];
        cy  = ({1'b0, a} < sub9);
        ac  = ~(a[4] ^ diff9[4] ^ x[4]);
      end
      ebc_pkg::ALU_ANA: begin
        res = a & x;
        cy  = 1'b0;
        ac  = a[3] | x[3];
      end
      default: begin
        res = a;
        cy  = 1'b0;
        ac  = 1'b0;
      end
    endcase
  end

  // Pack flags
  always_comb begin
    result.res                    = res;
    result.flags[ebc_pkg::FLAG_S]  = res[7];
    result.flags[ebc_pkg::FLAG_Z]  = (res == 8'd0);
    result.flags[ebc_pkg::FLAG_AC] = ac;
    result.flags[ebc_pkg::FLAG_P]  = ~^res;
    result.flags[ebc_pkg::FLAG_CY] = cy;
  end

endmodule
